// ===== src/mac_keyed_node_table_with_aging_core_defines.svh =====
// ----------------------------------------------------------------------------
// Node table assertion macros
// Shared concurrent assertion helpers for the node table RTL.
// ----------------------------------------------------------------------------
`ifndef MAC_KEYED_NODE_TABLE_WITH_AGING_CORE_DEFINES_SVH
`define MAC_KEYED_NODE_TABLE_WITH_AGING_CORE_DEFINES_SVH

// Checked on every clock edge outside reset
`define MKT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define MKT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mkt_pkg.sv =====
// ----------------------------------------------------------------------------
// Node table package
// Sizes, entry record and hello status codes shared by the node table.
// ----------------------------------------------------------------------------
package mkt_pkg;

    localparam int N     = 16;
    localparam int IDX_W = $clog2(N);
    localparam int CNT_W = $clog2(N + 1);

    typedef struct packed {
        logic               active;
        logic               online;
        logic [47:0]        mac;
        logic [31:0]        last_seen;
        logic signed [15:0] temperature;
        logic [15:0]        humidity;
    } t_entry;

    typedef enum logic [1:0] {
        HS_NONE   = 2'd0,
        HS_UPDATE = 2'd1,
        HS_NEW    = 2'd2,
        HS_FULL   = 2'd3
    } t_hstat;

endpackage

// ===== src/mkt_cell.sv =====
// ----------------------------------------------------------------------------
// Node table cell
// Holds one table entry and takes its neighbor's entry when the ring shifts.
// ----------------------------------------------------------------------------
module mkt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  mkt_pkg::t_entry i_d,
    output mkt_pkg::t_entry o_q
);
    import mkt_pkg::*;

    t_entry r_entry;

    // entry storage, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_d;
        end
    end

    assign o_q = r_entry;

endmodule

// ===== src/mkt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Node table controller
// Walks the entry ring twice per word: aging and lookup, then update and query.
// ----------------------------------------------------------------------------
`include "mac_keyed_node_table_with_aging_core_defines.svh"

module mkt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_now_time,
    input  logic                i_hello_valid,
    input  logic [47:0]         i_node_mac,
    input  logic signed [15:0]  i_temperature,
    input  logic [15:0]         i_humidity,
    input  logic [3:0]          i_query_index,
    input  logic [31:0]         i_limit,
    input  mkt_pkg::t_entry     i_head,
    output mkt_pkg::t_entry     o_tail,
    output logic                o_shift,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_hello_status,
    output logic [3:0]          o_hello_slot,
    output logic [4:0]          o_online_count,
    output logic [4:0]          o_went_offline,
    output logic                o_query_found,
    output logic [3:0]          o_query_slot,
    output logic [47:0]         o_query_mac,
    output logic signed [15:0]  o_query_temperature,
    output logic [15:0]         o_query_humidity
);
    import mkt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_AGE, S_UPD, S_OUT} t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_k;
    logic [31:0]        r_now;
    logic               r_hello;
    logic [47:0]        r_mac;
    logic signed [15:0] r_temp;
    logic [15:0]        r_hum;
    logic [3:0]         r_qidx;
    logic               r_match;
    logic [IDX_W-1:0]   r_mslot;
    logic               r_free;
    logic [IDX_W-1:0]   r_fslot;
    t_hstat             r_status;
    logic [IDX_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_off;
    logic [CNT_W-1:0]   r_count;
    logic               r_qfound;
    logic [IDX_W-1:0]   r_qslot;
    logic [47:0]        r_qmac;
    logic signed [15:0] r_qtemp;
    logic [15:0]        r_qhum;
    logic               r_oval;

    logic        accept;
    logic        last;
    logic        age_on;
    logic        hit_match;
    logic        hit_free;
    logic        hit;
    t_entry      aged;
    t_entry      upd;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign last    = (r_k == IDX_W'(N - 1));
    assign o_shift = (r_state == S_AGE) || (r_state == S_UPD);

    // per-entry work on the head of the ring
    always_comb begin
        age_on    = (r_now - i_head.last_seen) < i_limit;
        aged      = i_head;
        if (i_head.active) begin
            aged.online = age_on;
        end
        hit_match = i_head.active && (i_head.mac == r_mac);
        hit_free  = !i_head.active;
        hit       = ((r_status == HS_UPDATE) || (r_status == HS_NEW)) && (r_k == r_slot);
        upd       = i_head;
        if (hit) begin
            upd.active      = 1'b1;
            upd.online      = 1'b1;
            upd.mac         = r_mac;
            upd.last_seen   = r_now;
            upd.temperature = r_temp;
            upd.humidity    = r_hum;
        end
        unique case (r_state)
            S_AGE:   o_tail = aged;
            S_UPD:   o_tail = upd;
            default: o_tail = i_head;
        endcase
    end

    // sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_oval   <= 1'b0;
            r_status <= HS_NONE;
            r_qfound <= 1'b0;
            r_count  <= '0;
        end else begin
            // result taken; S_OUT reloads it itself
            if (r_oval && !i_stall && (r_state != S_OUT)) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now    <= i_now_time;
                        r_hello  <= i_hello_valid;
                        r_mac    <= i_node_mac;
                        r_temp   <= i_temperature;
                        r_hum    <= i_humidity;
                        r_qidx   <= i_query_index;
                        r_match  <= 1'b0;
                        r_free   <= 1'b0;
                        r_off    <= '0;
                        r_status <= HS_NONE;
                        r_k      <= '0;
                        r_state  <= S_AGE;
                    end
                end
                S_AGE: begin
                    if (i_head.active && i_head.online && !age_on) begin
                        r_off <= r_off + 1'b1;
                    end
                    if (!r_match && hit_match) begin
                        r_match <= 1'b1;
                        r_mslot <= r_k;
                    end
                    if (!r_free && hit_free) begin
                        r_free  <= 1'b1;
                        r_fslot <= r_k;
                    end
                    r_k <= r_k + 1'b1;
                    if (last) begin
                        // settle the hello outcome from the lookup pass
                        priority if (!r_hello) begin
                            r_status <= HS_NONE;
                            r_slot   <= '0;
                        end else if (r_match || hit_match) begin
                            r_status <= HS_UPDATE;
                            r_slot   <= r_match ? r_mslot : r_k;
                        end else if (r_free || hit_free) begin
                            r_status <= HS_NEW;
                            r_slot   <= r_free ? r_fslot : r_k;
                        end else begin
                            r_status <= HS_FULL;
                            r_slot   <= '0;
                        end
                        r_count  <= '0;
                        r_qfound <= 1'b0;
                        r_qslot  <= '0;
                        r_qmac   <= '0;
                        r_qtemp  <= '0;
                        r_qhum   <= '0;
                        r_state  <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd.active && upd.online) begin
                        if (!r_qfound && (r_count == CNT_W'(r_qidx))) begin
                            r_qfound <= 1'b1;
                            r_qslot  <= r_k;
                            r_qmac   <= upd.mac;
                            r_qtemp  <= upd.temperature;
                            r_qhum   <= upd.humidity;
                        end
                        r_count <= r_count + 1'b1;
                    end
                    r_k <= r_k + 1'b1;
                    if (last) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_oval || !i_stall) begin
                        r_oval              <= 1'b1;
                        o_hello_status      <= r_status;
                        o_hello_slot        <= 4'(r_slot);
                        o_online_count      <= 5'(r_count);
                        o_went_offline      <= 5'(r_off);
                        o_query_found       <= r_qfound;
                        o_query_slot        <= 4'(r_qslot);
                        o_query_mac         <= r_qmac;
                        o_query_temperature <= r_qtemp;
                        o_query_humidity    <= r_qhum;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_oval;

    `MKT_ASSERT(a_age_to_upd, i_clk, i_rst_n, (r_state == S_AGE && last) |=> (r_state == S_UPD), "aging pass did not hand over to update pass")
    `MKT_ASSERT(a_idle_k_zero, i_clk, i_rst_n, (r_state == S_IDLE) |-> (r_k == '0), "ring walk not aligned at idle")
    `MKT_ASSERT(a_qfound_rank, i_clk, i_rst_n, (r_state == S_OUT && r_qfound) |-> (r_count > CNT_W'(r_qidx)), "query found beyond online count")

endmodule

// ===== src/mac_keyed_node_table_with_aging_core.sv =====
// ----------------------------------------------------------------------------
// MAC-keyed node table with aging
// Sixteen-entry node table kept in a ring of cells, aged and queried per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (i_valid / o_stall) carries a timestamp, an optional hello and
//   a query rank. The block ages every entry against the stale limit, applies
//   the hello (update, new slot, or table full) and reports the online count,
//   the entries that went offline and the queried online entry.
//   Output word (o_valid / i_stall): one result per input word.
//   Config (i_cfg_valid / o_cfg_ready): writes the stale limit; ready is
//   always high, write only while the block is idle.
// Timing:
//   The entries circulate through a ring of N cells, one entry per cycle.
//   A new word is taken only once the last one has passed every step: one lap
//   for aging and lookup, one lap for the update and the ranked query, the
//   load of the output register, and the return to idle to take the next word.
//   o_valid rises when the output register is loaded after the update lap.
//   A finished result waits in the output register while i_stall is high;
//   the next word can be taken meanwhile, and its result waits behind it.
// Reset: clears every entry and sets the stale limit to 10000.
// ----------------------------------------------------------------------------
module mac_keyed_node_table_with_aging_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_now_time,
    input  logic               i_hello_valid,
    input  logic [47:0]        i_node_mac,
    input  logic signed [15:0] i_temperature,
    input  logic [15:0]        i_humidity,
    input  logic [3:0]         i_query_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_hello_status,
    output logic [3:0]         o_hello_slot,
    output logic [4:0]         o_online_count,
    output logic [4:0]         o_went_offline,
    output logic               o_query_found,
    output logic [3:0]         o_query_slot,
    output logic [47:0]        o_query_mac,
    output logic signed [15:0] o_query_temperature,
    output logic [15:0]        o_query_humidity,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import mkt_pkg::*;

    logic [31:0] r_limit;
    t_entry      ring_q [N];
    t_entry      tail;
    logic        shift;

    // stale limit register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= 32'd10000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // ring of entry cells, head at index 0, controller feeds the last cell
    for (genvar g = 0; g < N; g++) begin : g_cell
        t_entry d;
        if (g == N - 1) begin : g_tail
            assign d = tail;
        end else begin : g_mid
            assign d = ring_q[g + 1];
        end
        mkt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_d     (d),
            .o_q     (ring_q[g])
        );
    end

    mkt_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_now_time          (i_now_time),
        .i_hello_valid       (i_hello_valid),
        .i_node_mac          (i_node_mac),
        .i_temperature       (i_temperature),
        .i_humidity          (i_humidity),
        .i_query_index       (i_query_index),
        .i_limit             (r_limit),
        .i_head              (ring_q[0]),
        .o_tail              (tail),
        .o_shift             (shift),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_hello_status      (o_hello_status),
        .o_hello_slot        (o_hello_slot),
        .o_online_count      (o_online_count),
        .o_went_offline      (o_went_offline),
        .o_query_found       (o_query_found),
        .o_query_slot        (o_query_slot),
        .o_query_mac         (o_query_mac),
        .o_query_temperature (o_query_temperature),
        .o_query_humidity    (o_query_humidity)
    );

endmodule
